[hw/rtl/ptx_pkg.sv]
package ptx_pkg;

    // Fixed binary points of the number formats.
    localparam int COORD_FRAC = 16;
    localparam int COEFF_FRAC = 12;

    localparam int NUM_ROWS  = 4;
    localparam int NUM_COLS  = 4;
    localparam int NUM_LANES = 3;
    localparam int REG_W     = 64;
    localparam int ADDR_W    = 5;

    // Register indexes, taken from paddr[4:3].
    localparam logic [1:0] REG_ROW0 = 2'd0;
    localparam logic [1:0] REG_ROW1 = 2'd1;
    localparam logic [1:0] REG_ROW2 = 2'd2;
    localparam logic [1:0] REG_ROW3 = 2'd3;

    // Reset matrix is the identity with 1.0 = 4096 on the diagonal.
    localparam logic [REG_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
    localparam logic [REG_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
    localparam logic [REG_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
    localparam logic [REG_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;

endpackage

[hw/rtl/ptx_div.sv]
module ptx_div #(
    parameter int DW = 50,
    parameter int QW = 32,
    parameter int SW = 8
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       en,
    input  logic                                       in_valid,
    input  logic [ptx_pkg::NUM_LANES-1:0][DW-1:0]      in_rem,
    input  logic [ptx_pkg::NUM_LANES-1:0][QW-1:0]      in_low,
    input  logic [DW-1:0]                              in_d,
    input  logic [SW-1:0]                              in_side,
    output logic                                       out_valid,
    output logic [ptx_pkg::NUM_LANES-1:0][QW-1:0]      out_q,
    output logic [SW-1:0]                              out_side
);
    import ptx_pkg::*;

    // One restoring step per stage: a remainder that starts below the divisor
    // takes one numerator bit and gives one quotient bit, MSB first.
    logic [NUM_LANES-1:0][DW-1:0] rem_reg  [QW];
    logic [NUM_LANES-1:0][QW-1:0] low_reg  [QW];
    logic [NUM_LANES-1:0][QW-1:0] q_reg    [QW];
    logic [DW-1:0]                d_reg    [QW];
    logic [SW-1:0]                side_reg [QW];
    logic [QW-1:0]                vld_reg;

    genvar st;
    generate
        for (st = 0; st < QW; st++) begin : g_stage
            logic [NUM_LANES-1:0][DW-1:0] rem_src;
            logic [NUM_LANES-1:0][QW-1:0] low_src;
            logic [NUM_LANES-1:0][QW-1:0] q_src;
            logic [DW-1:0]                d_src;
            logic [SW-1:0]                side_src;
            logic                         vld_src;
            logic [NUM_LANES-1:0][DW-1:0] rem_next;
            logic [NUM_LANES-1:0][QW-1:0] low_next;
            logic [NUM_LANES-1:0][QW-1:0] q_next;

            if (st == 0) begin : g_first
                assign rem_src  = in_rem;
                assign low_src  = in_low;
                assign q_src    = '0;
                assign d_src    = in_d;
                assign side_src = in_side;
                assign vld_src  = in_valid;
            end else begin : g_rest
                assign rem_src  = rem_reg[st-1];
                assign low_src  = low_reg[st-1];
                assign q_src    = q_reg[st-1];
                assign d_src    = d_reg[st-1];
                assign side_src = side_reg[st-1];
                assign vld_src  = vld_reg[st-1];
            end

            always_comb begin
                logic [DW:0] trial;
                for (int l = 0; l < NUM_LANES; l++) begin
                    trial = {rem_src[l], low_src[l][QW-1]};
                    if (trial >= {1'b0, d_src}) begin
                        rem_next[l] = DW'(trial - {1'b0, d_src});
                        q_next[l]   = {q_src[l][QW-2:0], 1'b1};
                    end else begin
                        rem_next[l] = trial[DW-1:0];
                        q_next[l]   = {q_src[l][QW-2:0], 1'b0};
                    end
                    low_next[l] = {low_src[l][QW-2:0], 1'b0};
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[st] <= 1'b0;
                end else if (en) begin
                    vld_reg[st] <= vld_src;
                end
                if (en) begin
                    rem_reg[st]  <= rem_next;
                    low_reg[st]  <= low_next;
                    q_reg[st]    <= q_next;
                    d_reg[st]    <= d_src;
                    side_reg[st] <= side_src;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QW-1];
    assign out_q     = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

[hw/rtl/point_transform_4x4_projective_core.sv]
// Homogeneous 4x4 point transform with perspective divide.
// The input stream carries one point per request: x, y and z, signed fixed
// point, packed in s_tdata. The block multiplies (x, y, z, 1) by the matrix
// held in four 64-bit APB registers (one row each, at byte addresses 0, 8,
// 16 and 24) and returns x', y' and z' on the output stream. When w' is
// neither zero nor exactly one, the three results are true quotients by w'.
// m_tuser bit 0 says the divide was applied, bit 1 that a result clamped.
// Throughput is one request per cycle while no result is held. The
// pipeline has one stage for the products, one for the row sums, one for
// magnitudes and the overflow test, one stage per quotient bit in the
// shared-divisor divider, and the output register.
// Reset clears all valid bits and loads the identity matrix. When the
// receiver holds m_tready low with a result waiting, the whole pipeline
// freezes and s_tready drops in the same cycle; nothing is lost or repeated.
// The matrix must only be rewritten while no request is in flight.
module point_transform_4x4_projective_core #(
    parameter int COORD_WIDTH = 32,
    parameter int COEFF_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: in_x, in_y, in_z from the lowest bit up
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    // m_tdata: out_x, out_y, out_z from the lowest bit up
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
    // m_tuser: divided, saturated from the lowest bit up
    output logic [1:0]                          m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptx_pkg::ADDR_W-1:0]          paddr,
    input  logic [ptx_pkg::REG_W-1:0]           pwdata,
    output logic [ptx_pkg::REG_W-1:0]           prdata,
    output logic                                pready
);
    import ptx_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int KW     = COEFF_WIDTH;
    localparam int TD_W   = ((3*CW+7)/8)*8;
    localparam int PW     = CW + KW;
    // Four products of at most 2^(CW+KW-2) each, plus a sign bit and margin.
    localparam int ACC_W  = CW + KW + 2;
    localparam int NUM_W  = ACC_W + COORD_FRAC;
    localparam int EXT_W  = REG_W + NUM_COLS*KW;

    localparam logic [ACC_W-1:0] W_ONE = ACC_W'(1) << (COORD_FRAC + COEFF_FRAC);
    localparam logic [CW-1:0]    LIM_P = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]    LIM_N = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic                             divide;
        logic [NUM_LANES-1:0]             neg;
        logic [NUM_LANES-1:0]             ovf;
        logic [NUM_LANES-1:0]             nd_sat;
        logic [NUM_LANES-1:0][CW-1:0]     nd_val;
    } side_t;
    localparam int SW = $bits(side_t);

    // ---------------------------------------------------------------
    // Configuration registers. Writes complete in the APB access phase.
    // ---------------------------------------------------------------
    logic [REG_W-1:0] mat_reg  [NUM_ROWS];
    logic [REG_W-1:0] mat_next [NUM_ROWS];
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            mat_next[r] = mat_reg[r];
        end
        if (cfg_wr) begin
            case (paddr[4:3])
                REG_ROW0: mat_next[0] = pwdata;
                REG_ROW1: mat_next[1] = pwdata;
                REG_ROW2: mat_next[2] = pwdata;
                REG_ROW3: mat_next[3] = pwdata;
                default:  mat_next[0] = mat_reg[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg[0] <= ROW0_RST;
            mat_reg[1] <= ROW1_RST;
            mat_reg[2] <= ROW2_RST;
            mat_reg[3] <= ROW3_RST;
        end else begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                mat_reg[r] <= mat_next[r];
            end
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_ROW0: prdata = mat_reg[0];
            REG_ROW1: prdata = mat_reg[1];
            REG_ROW2: prdata = mat_reg[2];
            REG_ROW3: prdata = mat_reg[3];
            default:  prdata = '0;
        endcase
    end

    // The whole pipeline advances together unless a result is held.
    logic en;
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // ---------------------------------------------------------------
    // Coefficient extraction. A column that would start at bit 64 or
    // beyond reads as zero, and bits above bit 63 read as zero.
    // ---------------------------------------------------------------
    logic signed [KW-1:0] coef [NUM_ROWS][NUM_COLS];

    genvar gr, gc;
    generate
        for (gr = 0; gr < NUM_ROWS; gr++) begin : g_row
            logic [EXT_W-1:0] row_ext;
            assign row_ext = {{(NUM_COLS*KW){1'b0}}, mat_reg[gr]};
            for (gc = 0; gc < NUM_COLS; gc++) begin : g_col
                if (gc*KW >= REG_W) begin : g_zero
                    assign coef[gr][gc] = '0;
                end else begin : g_take
                    assign coef[gr][gc] = row_ext[gc*KW +: KW];
                end
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // Stage 1: the twelve coordinate products, plus the constant column.
    // ---------------------------------------------------------------
    logic signed [CW-1:0] coord [NUM_LANES];
    logic signed [PW-1:0] p_reg [NUM_ROWS][NUM_LANES];
    logic signed [KW-1:0] k_reg [NUM_ROWS];
    logic                 v1_reg;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            coord[l] = s_tdata[l*CW +: CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
        if (en) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                for (int c = 0; c < NUM_LANES; c++) begin
                    p_reg[r][c] <= PW'(coord[c] * coef[r][c]);
                end
                k_reg[r] <= coef[r][NUM_COLS-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: exact row sums. The w column multiplies 1.0 in Q16.
    // ---------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_reg  [NUM_ROWS];
    logic signed [ACC_W-1:0] acc_next [NUM_ROWS];
    logic                    v2_reg;

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            acc_next[r] = ACC_W'(p_reg[r][0]) + ACC_W'(p_reg[r][1]) + ACC_W'(p_reg[r][2])
                        + {{(ACC_W-KW-COORD_FRAC){k_reg[r][KW-1]}}, k_reg[r],
                           {COORD_FRAC{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                acc_reg[r] <= acc_next[r];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: magnitudes, divide decision, quotient overflow test and
    // the finished result for the no-divide case.
    // ---------------------------------------------------------------
    logic [NUM_LANES-1:0][ACC_W-1:0] rem0_next;
    logic [NUM_LANES-1:0][CW-1:0]    low0_next;
    logic [ACC_W-1:0]                wmag_next;
    side_t                           side_next;

    logic [NUM_LANES-1:0][ACC_W-1:0] rem0_reg;
    logic [NUM_LANES-1:0][CW-1:0]    low0_reg;
    logic [ACC_W-1:0]                wmag_reg;
    side_t                           side3_reg;
    logic                            v3_reg;

    always_comb begin
        logic             wneg;
        logic             aneg;
        logic [ACC_W-1:0] amag;
        logic [NUM_W-1:0] num;
        logic [ACC_W-1:0] shr;
        logic [CW-1:0]    lim;
        logic [CW-1:0]    ndm;

        wneg      = acc_reg[3][ACC_W-1];
        wmag_next = wneg ? ACC_W'(-acc_reg[3]) : ACC_W'(acc_reg[3]);
        side_next.divide = (acc_reg[3] != '0) && (acc_reg[3] != W_ONE);

        for (int l = 0; l < NUM_LANES; l++) begin
            aneg = acc_reg[l][ACC_W-1];
            amag = aneg ? ACC_W'(-acc_reg[l]) : ACC_W'(acc_reg[l]);
            num  = {amag, {COORD_FRAC{1'b0}}};

            rem0_next[l]     = ACC_W'(num >> CW);
            low0_next[l]     = num[CW-1:0];
            side_next.ovf[l] = (num >> CW) >= NUM_W'(wmag_next);
            side_next.neg[l] = side_next.divide ? (aneg ^ wneg) : aneg;

            shr = amag >> COEFF_FRAC;
            lim = aneg ? LIM_N : LIM_P;
            side_next.nd_sat[l] = shr > ACC_W'(lim);
            ndm = side_next.nd_sat[l] ? lim : shr[CW-1:0];
            side_next.nd_val[l] = aneg ? CW'(-ndm) : ndm;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            rem0_reg  <= rem0_next;
            low0_reg  <= low0_next;
            wmag_reg  <= wmag_next;
            side3_reg <= side_next;
        end
    end

    // ---------------------------------------------------------------
    // Divider: one quotient bit per stage, three lanes sharing |w|.
    // ---------------------------------------------------------------
    logic                         dv_valid;
    logic [NUM_LANES-1:0][CW-1:0] dv_q;
    logic [SW-1:0]                dv_side_bits;
    side_t                        dv_side;

    ptx_div #(
        .DW (ACC_W),
        .QW (CW),
        .SW (SW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rem    (rem0_reg),
        .in_low    (low0_reg),
        .in_d      (wmag_reg),
        .in_side   (side3_reg),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_side  (dv_side_bits)
    );

    assign dv_side = side_t'(dv_side_bits);

    // ---------------------------------------------------------------
    // Output stage: clamp the quotients, apply signs, pick the case.
    // ---------------------------------------------------------------
    logic [NUM_LANES-1:0][CW-1:0] res_next;
    logic                         sat_next;
    logic [TD_W-1:0]              m_data_reg;
    logic [1:0]                   m_user_reg;

    always_comb begin
        logic [CW-1:0] lim;
        logic          qsat;
        logic [CW-1:0] qm;

        sat_next = 1'b0;
        for (int l = 0; l < NUM_LANES; l++) begin
            lim  = dv_side.neg[l] ? LIM_N : LIM_P;
            qsat = dv_side.ovf[l] || (dv_q[l] > lim);
            qm   = qsat ? lim : dv_q[l];
            if (dv_side.divide) begin
                res_next[l] = dv_side.neg[l] ? CW'(-qm) : qm;
                sat_next    = sat_next | qsat;
            end else begin
                res_next[l] = dv_side.nd_val[l];
                sat_next    = sat_next | dv_side.nd_sat[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
        if (en) begin
            m_data_reg <= TD_W'(res_next);
            m_user_reg <= {sat_next, dv_side.divide};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // ---------------------------------------------------------------
    // Checks.
    // ---------------------------------------------------------------

    // A clamped result shows at least one coordinate at a range limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |->
            m_tdata[CW-1:0] == LIM_P || m_tdata[CW-1:0] == LIM_N ||
            m_tdata[2*CW-1:CW] == LIM_P || m_tdata[2*CW-1:CW] == LIM_N ||
            m_tdata[3*CW-1:2*CW] == LIM_P || m_tdata[3*CW-1:2*CW] == LIM_N)
        else $error("saturated flag without a clamped coordinate");

    // A held result freezes the pipeline, so the input side must stall too.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while the output is stalled");

    // No result can appear in the first cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

[tb/sv/tb_point_transform_4x4_projective_core.sv]
`timescale 1ns / 1ps

// Scoreboard for the projective point transform. It holds its own copy of
// the four matrix rows, computes the expected point for every accepted
// request, and compares each result against the oldest expectation.
class ptx_scoreboard;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        divided;
        logic        saturated;
    } point_t;

    logic [63:0] rows[4];
    point_t      pending_points[$];
    int          error_count;

    function new();
        rows[0] = ptx_pkg::ROW0_RST;
        rows[1] = ptx_pkg::ROW1_RST;
        rows[2] = ptx_pkg::ROW2_RST;
        rows[3] = ptx_pkg::ROW3_RST;
        error_count = 0;
    endfunction

    function void set_row(int idx, logic [63:0] value);
        rows[idx] = value;
    endfunction

    // Exact dot product of one row with (x, y, z, 1.0).
    function logic signed [127:0] row_sum(logic [63:0] row, logic signed [31:0] x,
                                          logic signed [31:0] y, logic signed [31:0] z);
        logic signed [127:0] acc;
        logic signed [127:0] p[4];
        logic signed [15:0]  c;
        p[0] = x;
        p[1] = y;
        p[2] = z;
        p[3] = 128'sd1 << ptx_pkg::COORD_FRAC;
        acc = 0;
        for (int k = 0; k < 4; k++) begin
            c = row[16*k +: 16];
            acc = acc + p[k] * c;
        end
        return acc;
    endfunction

    // Scales or divides one lane, then clamps it to 32 bits.
    function logic [31:0] finish_lane(logic signed [127:0] acc, bit do_div,
                                      logic [127:0] wmag, bit wneg, ref bit sat);
        bit           neg;
        logic [127:0] mag;
        logic [127:0] lim;
        neg = acc[127];
        mag = neg ? -acc : acc;
        if (do_div) begin
            mag = (mag << ptx_pkg::COORD_FRAC) / wmag;
            neg = neg ^ wneg;
        end else begin
            mag = mag >> ptx_pkg::COEFF_FRAC;
        end
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (mag > lim) begin
            mag = lim;
            sat = 1;
        end
        return neg ? -mag[31:0] : mag[31:0];
    endfunction

    function void note_request(logic [95:0] data);
        logic signed [127:0] ax, ay, az, aw;
        logic [127:0]        wmag;
        bit                  do_div, wneg, sat;
        point_t              pt;
        ax = row_sum(rows[0], data[31:0], data[63:32], data[95:64]);
        ay = row_sum(rows[1], data[31:0], data[63:32], data[95:64]);
        az = row_sum(rows[2], data[31:0], data[63:32], data[95:64]);
        aw = row_sum(rows[3], data[31:0], data[63:32], data[95:64]);
        do_div = (aw != 0) &&
                 (aw != (128'sd1 << (ptx_pkg::COORD_FRAC + ptx_pkg::COEFF_FRAC)));
        wneg = aw[127];
        wmag = wneg ? -aw : aw;
        sat = 0;
        pt.px = finish_lane(ax, do_div, wmag, wneg, sat);
        pt.py = finish_lane(ay, do_div, wmag, wneg, sat);
        pt.pz = finish_lane(az, do_div, wmag, wneg, sat);
        pt.divided = do_div;
        pt.saturated = sat;
        pending_points.push_back(pt);
    endfunction

    function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        error_count++;
    endfunction

    function void check_result(logic [95:0] data, logic [1:0] flags);
        point_t pt;
        if (pending_points.size() == 0) begin
            report_mismatch("unexpected result", data[31:0], 32'h0);
            return;
        end
        pt = pending_points.pop_front();
        if (data[31:0] !== pt.px) report_mismatch("out_x", data[31:0], pt.px);
        if (data[63:32] !== pt.py) report_mismatch("out_y", data[63:32], pt.py);
        if (data[95:64] !== pt.pz) report_mismatch("out_z", data[95:64], pt.pz);
        if (flags[0] !== pt.divided) begin
            report_mismatch("divided", 32'(flags[0]), 32'(pt.divided));
        end
        if (flags[1] !== pt.saturated) begin
            report_mismatch("saturated", 32'(flags[1]), 32'(pt.saturated));
        end
    endfunction

endclass

module tb_point_transform_4x4_projective_core;

    import ptx_pkg::*;

    // The pipeline is COORD_WIDTH + 4 deep; the drain wait is sized above
    // that, and the watchdog well above it and the long receiver hold-off.
    localparam int LATENCY   = 36;
    localparam int WATCHDOG  = 20000;
    localparam int N_RANDOM  = 1500;
    localparam int HOLD_LEN  = 300;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [95:0]         s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [95:0]         m_tdata;
    logic [1:0]          m_tuser;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [REG_W-1:0]    pwdata = '0;
    logic [REG_W-1:0]    prdata;
    logic                pready;

    ptx_scoreboard point_sb;

    // Shapes of the sender and receiver: idle percentage and hold-off.
    int  send_idle_pct = 31;
    int  recv_idle_pct = 31;
    int  hold_cycles = 0;
    bit  hold_armed = 1'b0;
    bit  hold_taken = 1'b0;
    int  stall_count = 0;

    always #2 aclk = ~aclk;

    point_transform_4x4_projective_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Checks every accepted result and counts cycles without any handshake.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                point_sb.check_result(m_tdata, m_tuser);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                stall_count <= 0;
            end else begin
                stall_count <= stall_count + 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_count >= WATCHDOG) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random idling, or a counted hold-off once one is armed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (hold_armed && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cycles <= HOLD_LEN;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Writes one matrix row through a setup and an access cycle.
    task automatic write_row(input logic [1:0] idx, input logic [63:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        point_sb.set_row(int'(idx), value);
    endtask

    // Offers one point request and waits until the block takes it. The
    // scoreboard is told at the accepting edge, ahead of any result. The
    // valid line stays up into the next request unless the sender idles.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        point_sb.note_request({z, y, x});
    endtask

    // Lets everything in flight come out before the matrix changes.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (point_sb.pending_points.size() != 0) begin
            @(posedge aclk);
        end
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            3: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_coeff();
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(16'h1000 + $urandom_range(0, 16'h0800) - 16'h0400);
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_row();
        return {rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff()};
    endfunction

    initial begin
        logic [31:0] v;
        point_sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed points under the identity matrix: w is exactly one.
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        send_point(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000);
        drain();

        // Row 3 all zero: w is exactly zero, so no divide.
        write_row(REG_ROW3, 64'h0);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        drain();

        // Gains at the coefficient extremes make the lanes clamp both ways.
        write_row(REG_ROW0, 64'h7fff_7fff_7fff_7fff);
        write_row(REG_ROW1, 64'h8000_8000_8000_8000);
        write_row(REG_ROW2, 64'hffff_0001_8000_7fff);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0000_0001, 32'hffff_ffff, 32'h0000_0000);
        drain();

        // w taken from z: true divide with small and negative w, then w of one and zero.
        write_row(REG_ROW0, 64'h0000_0000_0000_1000);
        write_row(REG_ROW1, 64'h0000_0000_1000_0000);
        write_row(REG_ROW2, 64'h0000_1000_0000_0000);
        write_row(REG_ROW3, 64'h0000_1000_0000_0000);
        send_point(32'h0004_0000, 32'hfffc_0000, 32'h0002_0000);
        send_point(32'h0004_0000, 32'h0003_0000, 32'hfffe_0000);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
        drain();

        // Random phases, each with its own matrix. The first keeps both
        // sides busy every cycle; one phase holds the receiver off at length.
        for (int ph = 0; ph < 10; ph++) begin
            write_row(REG_ROW0, rand_row());
            write_row(REG_ROW1, rand_row());
            write_row(REG_ROW2, rand_row());
            if (ph % 3 == 0) begin
                write_row(REG_ROW3, 64'h1000_0000_0000_0000);
            end else begin
                write_row(REG_ROW3, rand_row());
            end
            send_idle_pct = (ph == 0) ? 0 : 31;
            recv_idle_pct = (ph == 0) ? 0 : 31;
            if (ph == 2) begin
                hold_armed = 1'b1;
            end
            for (int n = 0; n < N_RANDOM / 10; n++) begin
                v = rand_coord();
                send_point(v, rand_coord(), rand_coord());
            end
            drain();
        end

        if (point_sb.error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/ptx_pkg.sv
hw/rtl/ptx_div.sv
hw/rtl/point_transform_4x4_projective_core.sv
tb/sv/tb_point_transform_4x4_projective_core.sv
